[src/owr_pkg.sv]
package owr_pkg;

   localparam int RING_DEPTH = 64;
   localparam int IDX_BITS = 6;
   localparam int CNT_BITS = 7;
   localparam int NUM_BITS = 64;
   localparam int PAY_BITS = 32;

   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_POP = 3'd1;
   localparam logic [2:0] CMD_FIND = 3'd2;
   localparam logic [2:0] CMD_SINCE = 3'd3;
   localparam logic [2:0] CMD_SNAP = 3'd4;
   localparam logic [2:0] CMD_CLEAR = 3'd5;

   // Memory access request from the sequencer to the entry store.
   typedef struct packed {
      logic wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      logic [NUM_BITS-1:0] wr_number;
      logic [PAY_BITS-1:0] wr_payload;
      logic [IDX_BITS-1:0] rd_addr;
   } mem_req_type;

endpackage

[src/owr_store.sv]
module owr_store
   import owr_pkg::*;
(
   input logic clock,
   input mem_req_type mem_req,
   output logic [NUM_BITS-1:0] rd_number,
   output logic [PAY_BITS-1:0] rd_payload
);

   logic [NUM_BITS-1:0] number_mem [RING_DEPTH];
   logic [PAY_BITS-1:0] payload_mem [RING_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         number_mem[mem_req.wr_addr] <= mem_req.wr_number;
         payload_mem[mem_req.wr_addr] <= mem_req.wr_payload;
      end
      rd_number <= number_mem[mem_req.rd_addr];
      rd_payload <= payload_mem[mem_req.rd_addr];
   end

endmodule

[src/overwrite_oldest_packet_ring.sv]
// Overwrite-oldest packet ring.
// Input items arrive on req_ (tdata: cmd, key_number, entry_payload, max_entries).
// Results leave on rsp_ (tdata fields listed at the port, tlast marks the
// final result of a command). Every command gives at least one result.
// The block takes one item at a time: req_tready is high only while idle.
// Push, clear and unused commands go from execution straight to the result
// fetch; pop first reads its oldest slot. Each push is finished before the next item is accepted.
// Find, since and snapshot walk the held entries through the single read
// port of the entry memory, each entry in an address step, then a compare
// and emit step; since walks twice (count, then emit).
// The oldest and newest numbers in every result are fetched through the same
// port before the result is shown.
// A stalled receiver holds the walk at the result register; nothing is lost.
// The next item may be accepted while the final result of the previous one
// still waits. No item is accepted in a cycle with a csr_wen write.
// A csr_wen write while idle trims excess oldest entries at once by moving pointers.
// Reset empties the ring, clears both counters and sets capacity to 64;
// the memory is not cleared since only values of held entries are ever used.
module overwrite_oldest_packet_ring
   import owr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // [2:0] cmd, [66:3] key_number, [98:67] entry_payload, [105:99] max_entries
   input logic [111:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // [0] ok, [64:1] out_number, [96:65] out_payload, [103:97] occupancy,
   // [167:104] oldest_number, [231:168] newest_number, [295:232] total_pushed,
   // [359:296] dropped_count
   output logic [359:0] rsp_tdata,
   output logic rsp_tlast,
   input logic csr_wen,
   input logic [6:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_EXEC = 4'd1;
   localparam logic [3:0] ST_RD = 4'd2;
   localparam logic [3:0] ST_CMP = 4'd3;
   localparam logic [3:0] ST_OLD = 4'd4;
   localparam logic [3:0] ST_OLDW = 4'd5;
   localparam logic [3:0] ST_NEW = 4'd6;
   localparam logic [3:0] ST_NEWW = 4'd7;
   localparam logic [3:0] ST_OUT = 4'd8;
   localparam logic [3:0] ST_POPW = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [IDX_BITS-1:0] oldest_ff, oldest_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [NUM_BITS-1:0] pushed_ff, pushed_in;
   logic [NUM_BITS-1:0] dropped_ff, dropped_in;
   logic [CNT_BITS-1:0] cap_ff, cap_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [NUM_BITS-1:0] key_ff, key_in;
   logic [PAY_BITS-1:0] pay_ff, pay_in;
   logic [CNT_BITS-1:0] lim_ff, lim_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] match_ff, match_in;
   logic [CNT_BITS-1:0] skip_ff, skip_in;
   logic pass_ff, pass_in;
   logic emitted_ff, emitted_in;
   logic more_ff, more_in;
   logic res_ok_ff, res_ok_in;
   logic [NUM_BITS-1:0] res_num_ff, res_num_in;
   logic [PAY_BITS-1:0] res_pay_ff, res_pay_in;
   logic [NUM_BITS-1:0] old_num_ff, old_num_in;
   logic [NUM_BITS-1:0] new_num_ff, new_num_in;
   logic vld_ff, vld_in;
   logic lst_ff, lst_in;
   logic [359:0] data_ff, data_in;

   mem_req_type mem_req;
   logic [NUM_BITS-1:0] rd_number;
   logic [PAY_BITS-1:0] rd_payload;

   owr_store u_store (
      .clock(clock),
      .mem_req(mem_req),
      .rd_number(rd_number),
      .rd_payload(rd_payload)
   );

   logic [CNT_BITS-1:0] cap_eff;
   logic [CNT_BITS-1:0] csr_cap;
   logic [CNT_BITS-1:0] walk_lim;
   logic hit;
   logic [IDX_BITS-1:0] walk_slot;

   always_comb begin
      csr_cap = csr_wdata;
      if (csr_cap == '0) begin
         csr_cap = CNT_BITS'(1);
      end else if (csr_cap > CNT_BITS'(RING_DEPTH)) begin
         csr_cap = CNT_BITS'(RING_DEPTH);
      end
      cap_eff = cap_ff;
      walk_lim = (lim_ff == '0 || lim_ff > count_ff) ? count_ff : lim_ff;
      if (cmd_ff == CMD_SNAP) begin
         walk_slot = oldest_ff + IDX_BITS'(count_ff - 7'd1 - idx_ff);
      end else begin
         walk_slot = oldest_ff + idx_ff[IDX_BITS-1:0];
      end
      hit = (cmd_ff == CMD_FIND) ? (rd_number == key_ff) : (rd_number > key_ff);
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_wen;

   always_comb begin
      state_in = state_ff;
      oldest_in = oldest_ff;
      count_in = count_ff;
      pushed_in = pushed_ff;
      dropped_in = dropped_ff;
      cap_in = cap_ff;
      cmd_in = cmd_ff;
      key_in = key_ff;
      pay_in = pay_ff;
      lim_in = lim_ff;
      idx_in = idx_ff;
      match_in = match_ff;
      skip_in = skip_ff;
      pass_in = pass_ff;
      emitted_in = emitted_ff;
      more_in = more_ff;
      res_ok_in = res_ok_ff;
      res_num_in = res_num_ff;
      res_pay_in = res_pay_ff;
      old_num_in = old_num_ff;
      new_num_in = new_num_ff;
      vld_in = vld_ff;
      lst_in = lst_ff;
      data_in = data_ff;
      mem_req = '0;
      mem_req.rd_addr = walk_slot;

      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_wen) begin
               cap_in = csr_cap;
               if (count_ff > csr_cap) begin
                  oldest_in = oldest_ff + IDX_BITS'(count_ff - csr_cap);
                  count_in = csr_cap;
                  dropped_in = dropped_ff + NUM_BITS'(count_ff - csr_cap);
               end
            end else if (req_tvalid && req_tready) begin
               cmd_in = req_tdata[2:0];
               key_in = req_tdata[66:3];
               pay_in = req_tdata[98:67];
               lim_in = req_tdata[105:99];
               idx_in = '0;
               match_in = '0;
               pass_in = 1'b0;
               emitted_in = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_ok_in = 1'b0;
            res_num_in = '0;
            res_pay_in = '0;
            more_in = 1'b0;
            unique case (cmd_ff)
               CMD_PUSH: begin
                  // At or above capacity, the oldest entries are dropped so the count equals capacity.
                  mem_req.wr_en = 1'b1;
                  mem_req.wr_addr = oldest_ff + count_ff[IDX_BITS-1:0];
                  mem_req.wr_number = key_ff;
                  mem_req.wr_payload = pay_ff;
                  pushed_in = pushed_ff + 64'd1;
                  res_ok_in = 1'b1;
                  if (count_ff >= cap_eff) begin
                     oldest_in = oldest_ff + IDX_BITS'(count_ff + 7'd1 - cap_eff);
                     count_in = cap_eff;
                     dropped_in = dropped_ff + NUM_BITS'(count_ff + 7'd1 - cap_eff);
                  end else begin
                     count_in = count_ff + 7'd1;
                  end
                  state_in = ST_OLD;
               end
               CMD_POP: begin
                  if (count_ff != '0) begin
                     state_in = ST_POPW;
                  end else begin
                     state_in = ST_OLD;
                  end
               end
               CMD_FIND, CMD_SINCE, CMD_SNAP: begin
                  state_in = ST_RD;
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  oldest_in = '0;
                  state_in = ST_OLD;
               end
               default: begin
                  state_in = ST_OLD;
               end
            endcase
         end
         ST_POPW: begin
            // Read of the oldest slot was issued in ST_EXEC.
            res_ok_in = 1'b1;
            res_num_in = rd_number;
            res_pay_in = rd_payload;
            oldest_in = oldest_ff + IDX_BITS'(1);
            count_in = count_ff - 7'd1;
            state_in = ST_OLD;
         end
         ST_RD: begin
            if ((cmd_ff == CMD_SNAP && idx_ff >= walk_lim)
                || (cmd_ff != CMD_SNAP && idx_ff >= count_ff)) begin
               if (cmd_ff == CMD_SINCE && !pass_ff) begin
                  pass_in = 1'b1;
                  idx_in = '0;
                  skip_in = (lim_ff != '0 && match_ff > lim_ff) ? match_ff - lim_ff : '0;
                  // From here on the match count holds the results still to come.
                  match_in = (lim_ff != '0 && match_ff > lim_ff) ? lim_ff : match_ff;
               end else begin
                  res_ok_in = 1'b0;
                  res_num_in = '0;
                  res_pay_in = '0;
                  more_in = 1'b0;
                  state_in = emitted_ff ? ST_IDLE : ST_OLD;
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            idx_in = idx_ff + 7'd1;
            state_in = ST_RD;
            if (cmd_ff == CMD_SNAP || ((cmd_ff == CMD_FIND || pass_ff) && hit)) begin
               if (cmd_ff == CMD_SINCE && skip_ff != '0) begin
                  skip_in = skip_ff - 7'd1;
               end else begin
                  res_ok_in = 1'b1;
                  res_num_in = rd_number;
                  res_pay_in = rd_payload;
                  emitted_in = 1'b1;
                  if (cmd_ff == CMD_FIND) begin
                     more_in = 1'b0;
                  end else if (cmd_ff == CMD_SNAP) begin
                     more_in = (idx_ff + 7'd1) < walk_lim;
                  end else begin
                     match_in = match_ff - 7'd1;
                     more_in = match_ff > 7'd1;
                  end
                  state_in = ST_OLD;
               end
            end else if (cmd_ff == CMD_SINCE && hit) begin
               match_in = match_ff + 7'd1;
            end
         end
         ST_OLD: begin
            mem_req.rd_addr = oldest_ff;
            state_in = ST_OLDW;
         end
         ST_OLDW: begin
            mem_req.rd_addr = oldest_ff + IDX_BITS'(count_ff - 7'd1);
            old_num_in = (count_ff != '0) ? rd_number : '0;
            state_in = ST_NEW;
         end
         ST_NEW: begin
            new_num_in = (count_ff != '0) ? rd_number : '0;
            state_in = ST_NEWW;
         end
         ST_NEWW: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!vld_ff || rsp_tready) begin
               vld_in = 1'b1;
               // A walk resumes only when another result of this item will follow.
               lst_in = !more_ff;
               data_in = {dropped_ff, pushed_ff, new_num_ff, old_num_ff, count_ff,
                          res_pay_ff, res_num_ff, res_ok_ff};
               state_in = more_ff ? ST_RD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         oldest_ff <= '0;
         count_ff <= '0;
         pushed_ff <= '0;
         dropped_ff <= '0;
         cap_ff <= CNT_BITS'(RING_DEPTH);
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         oldest_ff <= oldest_in;
         count_ff <= count_in;
         pushed_ff <= pushed_in;
         dropped_ff <= dropped_in;
         cap_ff <= cap_in;
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      pay_ff <= pay_in;
      lim_ff <= lim_in;
      idx_ff <= idx_in;
      match_ff <= match_in;
      skip_ff <= skip_in;
      pass_ff <= pass_in;
      emitted_ff <= emitted_in;
      more_ff <= more_in;
      res_ok_ff <= res_ok_in;
      res_num_ff <= res_num_in;
      res_pay_ff <= res_pay_in;
      old_num_ff <= old_num_in;
      new_num_ff <= new_num_in;
      lst_ff <= lst_in;
      data_ff <= data_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = lst_ff;

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff) else $error("occupancy above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready while busy");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && cmd_ff == CMD_PUSH |=> pushed_ff == $past(pushed_ff) + 64'd1)
      else $error("push not counted");
`endif

endmodule
